/* rtl/shm_pkg.sv */
// Package for the specular highlight mask block: widths, item and status
// types, state encoding and the sample clamp used by the front, queue and back.
// Depends on nothing.
`default_nettype none

package shm_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int SUM_W        = CHANNEL_BITS + 2;
    localparam int FRAC_W       = 16;
    localparam int SAT_W        = FRAC_W + 1;
    localparam int CNT_W        = $clog2(SAT_W);
    localparam int INT_THR_W    = FRAC_W + SUM_W;
    localparam int SAT_THR_W    = FRAC_W + SAT_W;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    // Queue depth must be a power of two so that the pointers wrap freely.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic REG_INTENSITY = 1'b0;
    localparam logic REG_SAT       = 1'b1;

    typedef enum logic {
        OP_MEASURE  = 1'b0,
        OP_CLASSIFY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        t_op              opcode;
        logic             frame_start;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] den;
        logic [SUM_W-1:0] num;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [FRAC_W-1:0] intensity_fraction;
        logic [FRAC_W-1:0] sat_fraction;
    } t_cfg;

    // Wide channels carry signed samples; a negative one counts as zero.
    function automatic logic [CHANNEL_BITS-1:0] clamp_sample(
        input logic [CHANNEL_BITS-1:0] raw
    );
        logic [CHANNEL_BITS-1:0] v;
        v = raw;
        if (CHANNEL_BITS > 8 && raw[CHANNEL_BITS-1]) begin
            v = '0;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/shm_front.sv */
// Front end: accepts pixels, clamps samples and forms the channel sum and
// the saturation numerator and divisor for the back end. Uses shm_pkg.
`default_nettype none

module shm_front import shm_pkg::*; (
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_opcode,
    input  wire logic                    i_frame_start,
    input  wire logic [CHANNEL_BITS-1:0] i_red,
    input  wire logic [CHANNEL_BITS-1:0] i_green,
    input  wire logic [CHANNEL_BITS-1:0] i_blue,
    input  wire t_q_status               i_q_status,
    output logic                         o_push,
    output t_item                        o_item
);

    logic [CHANNEL_BITS-1:0] r_s;
    logic [CHANNEL_BITS-1:0] g_s;
    logic [CHANNEL_BITS-1:0] b_s;
    logic [CHANNEL_BITS-1:0] lo;
    logic [SUM_W-1:0]        sum;
    logic [SUM_W-1:0]        den;
    logic [SUM_W-1:0]        lo3;

    always_comb begin
        r_s = clamp_sample(i_red);
        g_s = clamp_sample(i_green);
        b_s = clamp_sample(i_blue);
        lo  = r_s;
        if (g_s < lo) begin
            lo = g_s;
        end
        if (b_s < lo) begin
            lo = b_s;
        end
        sum = SUM_W'(r_s) + SUM_W'(g_s) + SUM_W'(b_s);
        lo3 = SUM_W'(lo) + SUM_W'({lo, 1'b0});
        // A black pixel divides by one, which gives full saturation.
        den = (sum == '0) ? SUM_W'(1) : sum;
    end

    assign o_ready            = ~i_q_status.full;
    assign o_push             = i_valid & ~i_q_status.full;
    assign o_item.opcode      = t_op'(i_opcode);
    assign o_item.frame_start = i_frame_start;
    assign o_item.sum         = sum;
    assign o_item.den         = den;
    assign o_item.num         = den - lo3;

endmodule

`default_nettype wire

/* rtl/shm_queue.sv */
// Short queue between the front end and the back end, held in registers.
// Uses shm_pkg for the item type and the depth.
`default_nettype none

module shm_queue import shm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output t_q_status  o_status
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_item         = r_mem[r_rd];

    always_comb begin
        do_push = i_push & ~o_status.full;
        do_pop  = i_pop & ~o_status.empty;
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt   = r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/shm_back.sv */
// Back end: serial saturation divider, peak tracking for the measure pass
// and the threshold tests and output register for the classify pass.
// Uses shm_pkg.
`default_nettype none

module shm_back import shm_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire t_item     i_item,
    input  wire t_q_status i_q_status,
    output logic           o_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output logic           o_highlight
);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [SUM_W:0]       r_rem;
    logic [SUM_W:0]       n_rem;
    logic [SAT_W-1:0]     r_quo;
    logic [SAT_W-1:0]     n_quo;
    t_item                r_item;
    t_item                n_item;
    logic [SUM_W-1:0]     r_peak_sum;
    logic [SUM_W-1:0]     n_peak_sum;
    logic [SAT_W-1:0]     r_peak_sat;
    logic [SAT_W-1:0]     n_peak_sat;
    logic [INT_THR_W-1:0] r_int_thr;
    logic [SAT_THR_W-1:0] r_sat_thr;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_out_hl;
    logic                 n_out_hl;

    logic                 rem_ge;
    logic [SUM_W-1:0]     rem_left;
    logic [SUM_W-1:0]     base_sum;
    logic [SAT_W-1:0]     base_sat;
    logic                 bright;
    logic                 pale;

    assign o_valid     = r_out_valid;
    assign o_highlight = r_out_hl;

    always_comb begin
        // The first step compares the numerator itself, which never exceeds
        // the divisor; later steps work on the doubled remainder.
        rem_ge   = (r_rem >= {1'b0, r_item.den});
        rem_left = rem_ge ? SUM_W'(r_rem - {1'b0, r_item.den}) : r_rem[SUM_W-1:0];
        base_sum = r_item.frame_start ? '0 : r_peak_sum;
        base_sat = r_item.frame_start ? '0 : r_peak_sat;
        bright   = ({r_item.sum, {FRAC_W{1'b0}}} > r_int_thr);
        pale     = ({r_quo, {FRAC_W{1'b0}}} < r_sat_thr);

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_item      = r_item;
        n_peak_sum  = r_peak_sum;
        n_peak_sat  = r_peak_sat;
        n_out_valid = r_out_valid & ~i_ready;
        n_out_hl    = r_out_hl;
        o_pop       = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_rem   = {1'b0, i_item.num};
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                n_quo = {r_quo[SAT_W-2:0], rem_ge};
                n_rem = {rem_left, 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SAT_W - 1)) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (r_item.opcode == OP_MEASURE) begin
                    n_peak_sum = (r_item.sum > base_sum) ? r_item.sum : base_sum;
                    n_peak_sat = (r_quo > base_sat) ? r_quo : base_sat;
                    n_state    = BK_IDLE;
                end else if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hl    = bright & pale;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_peak_sum  <= '0;
            r_peak_sat  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_peak_sum  <= n_peak_sum;
            r_peak_sat  <= n_peak_sat;
            r_out_valid <= n_out_valid;
        end
    end

    // The thresholds are registered from the peaks in the cycle after they change;
    // the divider runs before the next test, so they are always current.
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_item    <= n_item;
        r_out_hl  <= n_out_hl;
        r_int_thr <= INT_THR_W'(i_cfg.intensity_fraction) * INT_THR_W'(r_peak_sum);
        r_sat_thr <= SAT_THR_W'(i_cfg.sat_fraction) * SAT_THR_W'(r_peak_sat);
    end

endmodule

`default_nettype wire

/* rtl/specular_highlight_mask_core.sv */
// An accepted pixel is written into the queue in the same cycle. The back end then
// loads it, forms the saturation with the 17-step serial divider and finishes in a
// done state, where a classify result waits until the output register is free. It
// takes no new pixel from the queue until it is through with the last one.
// Reset (synchronous, active low) clears the state, the configuration, both
// peaks, the queue and the output valid; it needs no clearing pass.
`default_nettype none

module specular_highlight_mask_core import shm_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_opcode,
    input  wire logic                    i_frame_start,
    input  wire logic [CHANNEL_BITS-1:0] i_red,
    input  wire logic [CHANNEL_BITS-1:0] i_green,
    input  wire logic [CHANNEL_BITS-1:0] i_blue,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic                         o_highlight,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready
);

    t_cfg      r_cfg;
    t_item     front_item;
    t_item     head_item;
    t_q_status q_status;
    logic      push;
    logic      pop;
    logic      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_INTENSITY: r_cfg.intensity_fraction <= pwdata[FRAC_W-1:0];
                REG_SAT:       r_cfg.sat_fraction       <= pwdata[FRAC_W-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_INTENSITY: prdata = DATA_W'(r_cfg.intensity_fraction);
            REG_SAT:       prdata = DATA_W'(r_cfg.sat_fraction);
            default:       prdata = '0;
        endcase
    end

    shm_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_frame_start (i_frame_start),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_item        (front_item)
    );

    shm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    shm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (head_item),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_highlight (o_highlight)
    );

endmodule

`default_nettype wire
